/* hdl/websocket_frame_receiver_assert.svh */
// Assertion macros shared by the receiver RTL.
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wsfr_pkg.sv */
package wsfr_pkg;

    localparam int BYTE_W              = 8;
    localparam int LIMIT_W             = 24;
    localparam int LENGTH_BITS_DEFAULT = 64;
    localparam int COUNT_W             = 4;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam limit_t LIMIT_RESET    = 24'd1000000;
    localparam logic [3:0] OPCODE_BINARY = 4'h2;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam count_t EXT16_BYTES    = 4'd2;
    localparam count_t EXT64_BYTES    = 4'd8;
    localparam count_t MASK_KEY_BYTES = 4'd4;

endpackage

/* hdl/wsfr_stream_if.sv */
interface wsfr_in_if;
    import wsfr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
    import wsfr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t payload_byte;
    logic  last_in_frame;

    modport source (output valid, output payload_byte, output last_in_frame, input ready);
    modport sink   (input valid, input payload_byte, input last_in_frame, output ready);
endinterface

/* hdl/websocket_frame_receiver.sv */
// WebSocket receive-side deframer. Takes one stream byte per cycle on rx and
// follows the frame header (opcode, mask flag, 7-bit / 16-bit / 64-bit length,
// optional 4-byte mask key). Payload bytes of binary frames whose length is
// nonzero and below payload_limit leave on tx one word per byte, still masked as
// received, with last_in_frame on the final byte; all other payloads are
// counted off and dropped so the stream stays frame-aligned. Each payload byte
// passes through the header/length logic into a single result register;
// rx.ready falls only while that register holds a word the sink has not taken.
// Write payload_limit (cfg_we/cfg_wdata) only while the block is idle. Lengths
// keep their low LENGTH_BITS bits. No startup sequence after reset.
module websocket_frame_receiver #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    wsfr_in_if.sink          rx,
    wsfr_out_if.source       tx,
    input  logic             cfg_we,
    input  wsfr_pkg::limit_t cfg_wdata
);
    import wsfr_pkg::*;

    localparam int CMP_W = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;

    typedef logic [LENGTH_BITS-1:0] len_t;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] opcode_reg, opcode_next;
    logic       mask_reg, mask_next;
    count_t     count_reg, count_next;
    len_t       remaining_reg, remaining_next;
    logic       deliver_reg, deliver_next;
    limit_t     limit_reg, limit_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic       in_fire;
    logic       len_done;
    logic       start_payload;
    logic [6:0] len_code;

    assign rx.ready         = !out_valid_reg || tx.ready;
    assign in_fire          = rx.valid && rx.ready;
    assign tx.valid         = out_valid_reg;
    assign tx.payload_byte  = out_byte_reg;
    assign tx.last_in_frame = out_last_reg;
    assign len_code         = rx.rx_byte[6:0];

    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        deliver_next   = deliver_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        out_valid_next = out_valid_reg && !tx.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        len_done       = 1'b0;
        start_payload  = 1'b0;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_next      = rx.rx_byte[7];
                    remaining_next = '0;
                    if (len_code == LEN_CODE_EXT16)
                    begin
                        count_next = EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (len_code == LEN_CODE_EXT64)
                    begin
                        count_next = EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        remaining_next = len_t'(len_code);
                        len_done       = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    // big-endian: older bytes shift up, overflow falls off the top
                    remaining_next = {remaining_reg[LENGTH_BITS-BYTE_W-1:0], rx.rx_byte};
                    count_next     = count_reg - 4'd1;
                    len_done       = (count_reg == 4'd1);
                end
                PH_MASKKEY:
                begin
                    count_next    = count_reg - 4'd1;
                    start_payload = (count_reg == 4'd1);
                end
                PH_PAYLOAD:
                begin
                    remaining_next = remaining_reg - len_t'(1);
                    if (remaining_reg == len_t'(1))
                        phase_next = PH_HDR0;
                    if (deliver_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = rx.rx_byte;
                        out_last_next  = (remaining_reg == len_t'(1));
                    end
                end
                default:
                begin
                    opcode_next = rx.rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                if (mask_next)
                begin
                    count_next = MASK_KEY_BYTES;
                    phase_next = PH_MASKKEY;
                end
                else
                    start_payload = 1'b1;
            end

            if (start_payload)
            begin
                deliver_next = (opcode_reg == OPCODE_BINARY) &&
                               (remaining_next != '0) &&
                               (CMP_W'(remaining_next) < CMP_W'(limit_reg));
                phase_next   = (remaining_next == '0) ? PH_HDR0 : PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            count_reg     <= '0;
            remaining_reg <= '0;
            deliver_reg   <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            deliver_reg   <= deliver_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

`include "websocket_frame_receiver_assert.svh"

    `WSFR_ASSERT_NEXT(a_deliver_word, in_fire && phase_reg == PH_PAYLOAD && deliver_reg, out_valid_reg, "delivered payload byte produced no word")
    `WSFR_ASSERT_NEXT(a_header_silent, in_fire && phase_reg != PH_PAYLOAD, !out_valid_reg, "header byte produced a word")
    `WSFR_ASSERT_NOW(a_payload_nonzero, phase_reg == PH_PAYLOAD, remaining_reg != '0, "payload phase with zero bytes left")
    `WSFR_ASSERT_NOW(a_count_nonzero, phase_reg == PH_EXTLEN || phase_reg == PH_MASKKEY, count_reg != '0, "header byte count ran out")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import wsfr_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEFAULT;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD
    } rx_phase_t;

    typedef struct packed {
        byte_t data;
        logic  is_last;
    } payload_word_t;

    // Tracks frame structure byte by byte and queues the payload words the
    // block must deliver.
    class payload_tracker;
        limit_t              limit_reg;
        rx_phase_t           phase;
        logic [3:0]          opcode;
        logic                masked;
        count_t              count;
        logic [LEN_BITS-1:0] remaining;
        logic                deliver;
        payload_word_t       payload_due_q[$];
        int                  errors;

        function new();
            limit_reg = LIMIT_RESET;
            phase     = PH_HDR0;
            opcode    = '0;
            masked    = 1'b0;
            count     = '0;
            remaining = '0;
            deliver   = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return payload_due_q.size();
        endfunction

        function bit at_header();
            return phase == PH_HDR0;
        endfunction

        function void start_payload();
            deliver = (opcode == OPCODE_BINARY) && (remaining != '0) &&
                      (remaining < LEN_BITS'(limit_reg));
            phase   = (remaining == '0) ? PH_HDR0 : PH_PAYLOAD;
        endfunction

        function void after_length();
            if (masked)
            begin
                count = MASK_KEY_BYTES;
                phase = PH_MASKKEY;
            end
            else
                start_payload();
        endfunction

        // Restricts a random byte so any length it forms stays short.
        function byte_t tame(byte_t b);
            byte_t t;
            t = b;
            if (phase == PH_HDR1 && t[6:0] >= LEN_CODE_EXT16)
                t[6] = 1'b0;
            else if (phase == PH_EXTLEN && count > 4'd2)
                t = '0;
            else if (phase == PH_EXTLEN && count == 4'd2)
                t[7:1] = '0;
            return t;
        endfunction

        function void note_rx_byte(byte_t b);
            payload_word_t word;
            case (phase)
                PH_HDR1:
                begin
                    masked    = b[7];
                    remaining = '0;
                    if (b[6:0] == LEN_CODE_EXT16)
                    begin
                        count = EXT16_BYTES;
                        phase = PH_EXTLEN;
                    end
                    else if (b[6:0] == LEN_CODE_EXT64)
                    begin
                        count = EXT64_BYTES;
                        phase = PH_EXTLEN;
                    end
                    else
                    begin
                        remaining = LEN_BITS'(b[6:0]);
                        after_length();
                    end
                end
                PH_EXTLEN:
                begin
                    remaining = (remaining << 8) | LEN_BITS'(b);
                    count     = count - 4'd1;
                    if (count == '0)
                        after_length();
                end
                PH_MASKKEY:
                begin
                    count = count - 4'd1;
                    if (count == '0)
                        start_payload();
                end
                PH_PAYLOAD:
                begin
                    remaining = remaining - LEN_BITS'(1);
                    if (remaining == '0)
                        phase = PH_HDR0;
                    if (deliver)
                    begin
                        word.data    = b;
                        word.is_last = (remaining == '0);
                        payload_due_q.insert(payload_due_q.size(), word);
                    end
                end
                default:
                begin
                    opcode = b[3:0];
                    phase  = PH_HDR1;
                end
            endcase
        endfunction

        function void check_payload(byte_t data, logic is_last);
            payload_word_t want;
            if (payload_due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected word data=%02h last=%0b", $time, data, is_last);
                return;
            end
            want = payload_due_q.pop_front();
            if (want.data !== data || want.is_last !== is_last)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: word differs: want data=%02h last=%0b, got data=%02h last=%0b",
                             $time, want.data, want.is_last, data, is_last);
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    limit_t cfg_wdata;
    int     src_idle_pct;
    int     snk_stall_pct;
    int     bytes_sent;

    payload_tracker sb;

    wsfr_in_if  rx_if ();
    wsfr_out_if tx_if ();

    websocket_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .tx        (tx_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_if.valid && tx_if.ready)
            sb.check_payload(tx_if.payload_byte, tx_if.last_in_frame);
        tx_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic push_byte(input byte_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    // Block must be idle: all words out and the last byte through the pipe.
    task automatic program_limit(input limit_t value);
        rx_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.limit_reg = value;
    endtask

    initial
    begin
        byte_t      directed_seq[$] = '{
            8'h82, 8'h01, 8'hAA,                      // one-byte binary
            8'h82, 8'h00,                             // empty binary
            8'h81, 8'h02, 8'h11, 8'h22,               // text, dropped
            8'h82, 8'h82, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h00, 8'hFF,  // masked
            8'h02, 8'h7E, 8'h00, 8'h03, 8'h01, 8'h02, 8'h03,         // 16-bit length
            8'h89, 8'h00                              // ping, empty
        };
        limit_t     phase_limit[8] = '{24'hFFFFFF, 24'd1, 24'd300, 24'd0,
                                       24'd25, 24'd1000000, 24'd1, 24'd8};
        byte_t      frame_q[$];
        logic [3:0] opcode;
        logic       masked;
        int         len;
        int         sel;
        int         cut;

        sb            = new();
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        bytes_sent    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i])
            push_byte(directed_seq[i]);

        phase_limit[6] = limit_t'($urandom_range(400, 1));
        for (int p = 0; p < 8; p++)
        begin
            program_limit(phase_limit[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 28; snk_stall_pct = 28; end
            endcase
            bytes_sent = 0;
            // the frame in progress overruns this by about 70 bytes on average
            while (bytes_sent < 160)
            begin
                // realign after a cut frame or stray bytes
                while (!sb.at_header())
                    push_byte(sb.tame(byte_t'($urandom)));

                frame_q.delete();
                opcode = ($urandom_range(99) < 70) ? OPCODE_BINARY : 4'($urandom_range(15));
                masked = 1'($urandom_range(1));
                frame_q.insert(frame_q.size(), {4'($urandom_range(15)), opcode});
                sel = $urandom_range(99);
                if (sel < 12)
                    len = 0;
                else if (sel < 62)
                    len = $urandom_range(30, 1);
                else if (sel < 78)
                    len = $urandom_range(125, 31);
                else
                    len = $urandom_range(300);
                if (sel < 78)
                    frame_q.insert(frame_q.size(), {masked, 7'(len)});
                else if (sel < 90)
                begin
                    frame_q.insert(frame_q.size(), {masked, LEN_CODE_EXT16});
                    frame_q.insert(frame_q.size(), byte_t'(len >> 8));
                    frame_q.insert(frame_q.size(), byte_t'(len));
                end
                else
                begin
                    frame_q.insert(frame_q.size(), {masked, LEN_CODE_EXT64});
                    repeat (6) frame_q.insert(frame_q.size(), 8'h00);
                    frame_q.insert(frame_q.size(), byte_t'(len >> 8));
                    frame_q.insert(frame_q.size(), byte_t'(len));
                end
                if (masked)
                    repeat (4) frame_q.insert(frame_q.size(), byte_t'($urandom));
                repeat (len) frame_q.insert(frame_q.size(), byte_t'($urandom));

                cut = frame_q.size();
                if ($urandom_range(99) < 6)
                    cut = $urandom_range(frame_q.size() - 1, 1);
                for (int i = 0; i < cut; i++)
                    push_byte(frame_q[i]);

                if ($urandom_range(99) < 8)
                    repeat ($urandom_range(5, 1)) push_byte(sb.tame(byte_t'($urandom)));
            end
        end

        while (!sb.at_header())
            push_byte(sb.tame(byte_t'($urandom)));
        // masked binary frame with an all-ones 64-bit length: never delivered
        push_byte(8'h82);
        push_byte(8'hFF);
        repeat (8) push_byte(8'hFF);
        repeat (14) push_byte(byte_t'($urandom));
        rx_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("websocket_frame_receiver: match");
        else
            $display("websocket_frame_receiver: mismatch");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("websocket_frame_receiver: mismatch");
        $finish;
    end

endmodule
